>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold cons in the same cycle as ante.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Hold cons in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hw/rtl/pdsc_pkg.sv
// ----------------------------------------------------------------------------
// pdsc_pkg
// Types and codes shared by the date string checker modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pdsc_pkg;

   localparam int unsigned ChWidth     = 8;
   localparam int unsigned StatusWidth = 4;
   localparam int unsigned DataWidth   = 8;

   localparam logic [StatusWidth-1:0] ST_OK       = 4'd0;
   localparam logic [StatusWidth-1:0] ST_YEAR     = 4'd1;
   localparam logic [StatusWidth-1:0] ST_MONTH    = 4'd2;
   localparam logic [StatusWidth-1:0] ST_DAY      = 4'd3;
   localparam logic [StatusWidth-1:0] ST_HOUR     = 4'd4;
   localparam logic [StatusWidth-1:0] ST_MINUTE   = 4'd5;
   localparam logic [StatusWidth-1:0] ST_SECOND   = 4'd6;
   localparam logic [StatusWidth-1:0] ST_OHOUR    = 4'd7;
   localparam logic [StatusWidth-1:0] ST_APOS     = 4'd8;
   localparam logic [StatusWidth-1:0] ST_OMIN     = 4'd9;
   localparam logic [StatusWidth-1:0] ST_GARBAGE  = 4'd10;

   localparam logic [0:0] KIND_CHAR = 1'b0;
   localparam logic [0:0] KIND_END  = 1'b1;

   typedef enum logic [3:0] {
      PH_START  = 4'd0,
      PH_YEAR   = 4'd1,
      PH_MONTH  = 4'd2,
      PH_DAY    = 4'd3,
      PH_HOUR   = 4'd4,
      PH_MINUTE = 4'd5,
      PH_SECOND = 4'd6,
      PH_SIGN   = 4'd7,
      PH_OHOUR  = 4'd8,
      PH_APOS   = 4'd9,
      PH_OMIN   = 4'd10,
      PH_DONE   = 4'd11
   } phase_type;

   typedef struct packed {
      logic [0:0]         kind;
      logic [ChWidth-1:0] ch;
   } item_type;

   typedef struct packed {
      logic                   valid;
      logic [StatusWidth-1:0] status;
   } result_type;

endpackage

>>> hw/rtl/pdsc_in_stage.sv
// ----------------------------------------------------------------------------
// pdsc_in_stage
// Input register: holds one accepted transaction until the core takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdsc_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  pdsc_pkg::item_type req_item,
   input  logic              take,
   output logic              item_valid,
   output pdsc_pkg::item_type item
);

   logic               valid_ff, valid_in;
   pdsc_pkg::item_type item_ff, item_in;
   logic               load;

   assign req_tready = !valid_ff || take;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      item_in  = load ? req_item : item_ff;
      valid_in = load ? 1'b1 : (take ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> hw/rtl/pdsc_core.sv
// ----------------------------------------------------------------------------
// pdsc_core
// Parse state and one-character step of the date string check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdsc_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  pdsc_pkg::item_type   item,
   input  logic                 out_free,
   output logic                 take,
   output pdsc_pkg::result_type result
);

   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_Z     = 8'h5A;
   localparam logic [7:0] CH_APOS  = 8'h27;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   pdsc_pkg::phase_type phase_ff, phase_in;
   logic [2:0]          dpos_ff, dpos_in;
   logic [3:0]          fdig_ff, fdig_in;
   logic [3:0]          err_ff, err_in;
   logic                dseen_ff, dseen_in;

   logic       digit;
   logic [3:0] dval;
   logic [6:0] value;
   logic [3:0] range_err;
   logic [3:0] end_status;

   function automatic logic [3:0] range_check(pdsc_pkg::phase_type ph, logic [6:0] v);
      logic [3:0] e;
      e = pdsc_pkg::ST_OK;
      case (ph)
         pdsc_pkg::PH_MONTH:  if (v < 7'd1 || v > 7'd12) e = pdsc_pkg::ST_MONTH;
         pdsc_pkg::PH_DAY:    if (v < 7'd1 || v > 7'd31) e = pdsc_pkg::ST_DAY;
         pdsc_pkg::PH_HOUR:   if (v > 7'd23) e = pdsc_pkg::ST_HOUR;
         pdsc_pkg::PH_MINUTE: if (v > 7'd59) e = pdsc_pkg::ST_MINUTE;
         pdsc_pkg::PH_SECOND: if (v > 7'd59) e = pdsc_pkg::ST_SECOND;
         pdsc_pkg::PH_OHOUR:  if (v > 7'd23) e = pdsc_pkg::ST_OHOUR;
         default:             if (v > 7'd59) e = pdsc_pkg::ST_OMIN;
      endcase
      return e;
   endfunction

   assign digit = (item.ch >= CH_ZERO) && (item.ch <= CH_NINE);
   assign dval  = digit ? item.ch[3:0] : 4'd0;
   assign value = ({3'b000, fdig_ff} << 3) + ({3'b000, fdig_ff} << 1) + {3'b000, dval};
   assign range_err = range_check(phase_ff, value);

   assign take = item_valid && ((item.kind == pdsc_pkg::KIND_CHAR) || out_free);

   always_comb begin
      if (err_ff != pdsc_pkg::ST_OK) begin
         end_status = err_ff;
      end else begin
         case (phase_ff)
            pdsc_pkg::PH_START, pdsc_pkg::PH_YEAR: end_status = pdsc_pkg::ST_YEAR;
            pdsc_pkg::PH_SIGN, pdsc_pkg::PH_DONE:  end_status = pdsc_pkg::ST_OK;
            pdsc_pkg::PH_APOS:                     end_status = pdsc_pkg::ST_APOS;
            default: begin
               end_status = (dpos_ff == 3'd0) ? pdsc_pkg::ST_OK : pdsc_pkg::ST_GARBAGE;
            end
         endcase
      end
   end

   always_comb begin
      phase_in = phase_ff;
      dpos_in  = dpos_ff;
      fdig_in  = fdig_ff;
      err_in   = err_ff;
      dseen_in = dseen_ff;
      result   = '0;
      if (take) begin
         if (item.kind == pdsc_pkg::KIND_END) begin
            result.valid  = 1'b1;
            result.status = end_status;
            phase_in = pdsc_pkg::PH_START;
            dpos_in  = 3'd0;
            fdig_in  = 4'd0;
            err_in   = pdsc_pkg::ST_OK;
            dseen_in = 1'b0;
         end else if (err_ff == pdsc_pkg::ST_OK) begin
            case (phase_ff)
               pdsc_pkg::PH_START: begin
                  if (dseen_ff) begin
                     dseen_in = 1'b0;
                     if (item.ch == CH_COLON) begin
                        phase_in = pdsc_pkg::PH_YEAR;
                        dpos_in  = 3'd0;
                     end else begin
                        err_in = pdsc_pkg::ST_YEAR;
                     end
                  end else if (item.ch == CH_D) begin
                     dseen_in = 1'b1;
                  end else if (digit) begin
                     phase_in = pdsc_pkg::PH_YEAR;
                     dpos_in  = 3'd1;
                  end else begin
                     err_in = pdsc_pkg::ST_YEAR;
                  end
               end
               pdsc_pkg::PH_YEAR: begin
                  if (!digit) begin
                     err_in = pdsc_pkg::ST_YEAR;
                  end else if (dpos_ff >= 3'd3) begin
                     phase_in = pdsc_pkg::PH_MONTH;
                     dpos_in  = 3'd0;
                  end else begin
                     dpos_in = dpos_ff + 3'd1;
                  end
               end
               pdsc_pkg::PH_SIGN: begin
                  if (item.ch == CH_PLUS || item.ch == CH_MINUS || item.ch == CH_Z) begin
                     phase_in = pdsc_pkg::PH_OHOUR;
                  end else begin
                     err_in = pdsc_pkg::ST_GARBAGE;
                  end
               end
               pdsc_pkg::PH_APOS: begin
                  if (item.ch == CH_APOS) begin
                     phase_in = pdsc_pkg::PH_OMIN;
                  end else begin
                     err_in = pdsc_pkg::ST_APOS;
                  end
               end
               pdsc_pkg::PH_DONE: begin
                  err_in = pdsc_pkg::ST_GARBAGE;
               end
               default: begin
                  if (!digit) begin
                     err_in = pdsc_pkg::ST_GARBAGE;
                  end else if (dpos_ff == 3'd0) begin
                     fdig_in = dval;
                     dpos_in = 3'd1;
                  end else if (range_err != pdsc_pkg::ST_OK) begin
                     err_in = range_err;
                  end else begin
                     phase_in = pdsc_pkg::phase_type'(phase_ff + 4'd1);
                     dpos_in  = 3'd0;
                     fdig_in  = 4'd0;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pdsc_pkg::PH_START;
         dpos_ff  <= 3'd0;
         fdig_ff  <= 4'd0;
         err_ff   <= pdsc_pkg::ST_OK;
         dseen_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         dpos_ff  <= dpos_in;
         fdig_ff  <= fdig_in;
         err_ff   <= err_in;
         dseen_ff <= dseen_in;
      end
   end

endmodule

>>> hw/rtl/pdsc_out_stage.sv
// ----------------------------------------------------------------------------
// pdsc_out_stage
// Result register: holds one status transaction until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdsc_out_stage (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pdsc_pkg::result_type                 result,
   output logic                                 out_free,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [pdsc_pkg::StatusWidth-1:0]     status
);

   logic                               valid_ff, valid_in;
   logic [pdsc_pkg::StatusWidth-1:0]   status_ff, status_in;

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      status_in = result.valid ? result.status : status_ff;
      valid_in  = result.valid ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      status_ff <= status_in;
   end

   assign rsp_tvalid = valid_ff;
   assign status     = status_ff;

endmodule

>>> hw/rtl/pdf_date_string_checker_unit.sv
// ----------------------------------------------------------------------------
// pdf_date_string_checker_unit
// Streaming checker for PDF date strings of the form D:YYYYMMDDHHmmSSOHH'mm.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one transaction per character (req_tuser = 0,
//   req_tdata = character byte) or an end-of-string marker (req_tuser = 1,
//   req_tdata ignored). Characters return nothing; each end marker returns
//   one transaction on the rsp_ channel with the status code in
//   rsp_tdata[3:0] (0 = valid date, otherwise the first error found) and
//   clears the parse state for the next string.
//   Path: an accepted end marker passes the input register, then the
//   result register, before its status shows on rsp_; it waits in the
//   input register while the result register holds an untaken status.
//   Throughput: one transaction per cycle unless an end marker stalls, set
//   by the parse state update between the input and result registers.
//   Stall: while a status waits on rsp_tready, characters keep flowing;
//   the next end marker waits in the input register and req_tready drops.
//   Reset: synchronous, active high; clears the parse state and the valid
//   flags of both registers; the block is ready once reset is released.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pdf_date_string_checker_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] ch
   input  logic       req_tuser,   // [0] kind
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [3:0] status, [7:4] zero
);

   pdsc_pkg::item_type                 req_item;
   pdsc_pkg::item_type                 item;
   pdsc_pkg::result_type               result;
   logic                               item_valid;
   logic                               take;
   logic                               out_free;
   logic [pdsc_pkg::StatusWidth-1:0]   status;

   assign req_item.kind = req_tuser;
   assign req_item.ch   = req_tdata;

   pdsc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   pdsc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .out_free   (out_free),
      .take       (take),
      .result     (result)
   );

   pdsc_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status)
   );

   assign rsp_tdata = {{(pdsc_pkg::DataWidth - pdsc_pkg::StatusWidth){1'b0}}, status};

   `ASSERT_NEXT(a_end_loads_rsp, clock, reset, take && (item.kind == pdsc_pkg::KIND_END), rsp_tvalid)
   `ASSERT_NEXT(a_held_item_stays, clock, reset, item_valid && !take, item_valid)
   `ASSERT_SAME(a_result_only_on_end, clock, reset, result.valid, take && (item.kind == pdsc_pkg::KIND_END))
   `ASSERT_SAME(a_status_in_range, clock, reset, rsp_tvalid, status <= pdsc_pkg::ST_GARBAGE)

endmodule
